FILE: rtl/core/lsr_pkg.sv
package lsr_pkg;

  // Report layout
  localparam int NODE_ID_BYTES = 8;
  localparam int LINK_ID_BYTES = 32;

  // Result queue sizing (power of two)
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Result kinds
  localparam logic [2:0] KIND_TYPE       = 3'd0;
  localparam logic [2:0] KIND_NODE_BYTE  = 3'd1;
  localparam logic [2:0] KIND_LINK_COUNT = 3'd2;
  localparam logic [2:0] KIND_LINK_BYTE  = 3'd3;
  localparam logic [2:0] KIND_ITEM_COUNT = 3'd4;
  localparam logic [2:0] KIND_QOS_ITEM   = 3'd5;
  localparam logic [2:0] KIND_ERROR      = 3'd6;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_TRAILING  = 2'd2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_packet;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  link_index;
    logic [7:0]  field_byte;
    logic [7:0]  item_id;
    logic [15:0] item_value;
    logic [1:0]  error_code;
    logic        last;
  } out_beat_t;

endpackage

FILE: rtl/core/link_state_report_parser.sv
// Link-state QoS report parser. Takes one report byte per in_ beat, in wire
// order, and emits a typed result beat as each field completes: the type
// byte, each node id byte, the link count, then per link each link id byte,
// the item count and one beat per three-byte QoS item (id plus big-endian
// 16-bit value), tagged with the link index. A packet that ends early gets a
// truncation error beat after the result of its last byte; bytes after a
// complete report give nothing until the end mark, which gives one
// trailing-bytes error beat. Rate: one input byte per clock. The parser
// state updates in the same cycle the byte is taken and its results are
// registered into a 4-entry result queue that feeds out_. The queue drains
// one beat per clock while out_ready is high; in_ready drops whenever fewer
// than two queue entries are free, which only throttles input when the
// consumer stalls or right after a byte that yields a result plus an error.
module link_state_report_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lsr_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lsr_pkg::out_beat_t out_data
);
  import lsr_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE, PH_NODE, PH_COUNT, PH_LID, PH_ICNT, PH_ITEM, PH_TRAIL
  } phase_t;

  // Parser state
  phase_t     phase_r, phase_nxt;
  logic [7:0] fbc_r, fbc_nxt;          // bytes taken in the current field
  logic [7:0] links_rem_r, links_rem_nxt;
  logic [7:0] items_rem_r, items_rem_nxt;
  logic [7:0] cur_link_r, cur_link_nxt;
  logic [7:0] held_id_r, held_id_nxt;
  logic [7:0] held_hi_r, held_hi_nxt;

  // Result queue
  out_beat_t             queue_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0]  cnt_r, cnt_nxt;

  logic       in_acc, out_acc;
  logic [1:0] push_n;
  out_beat_t  res0, res1;
  logic       complete, clear_state;
  logic [7:0] fbc_inc;
  logic [7:0] b;
  logic       eop;

  assign b   = in_data.byte_in;
  assign eop = in_data.end_of_packet;

  // Keep room for the worst case of two results per byte.
  assign in_ready  = (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign out_data  = queue_r[rd_ptr_r];

  assign fbc_inc = fbc_r + 8'd1;

  // Per-byte step: next parser state and up to two result beats.
  always_comb begin
    phase_nxt     = phase_r;
    fbc_nxt       = fbc_r;
    links_rem_nxt = links_rem_r;
    items_rem_nxt = items_rem_r;
    cur_link_nxt  = cur_link_r;
    held_id_nxt   = held_id_r;
    held_hi_nxt   = held_hi_r;
    res0          = '0;
    res1          = '0;
    push_n        = 2'd0;
    complete      = 1'b0;
    clear_state   = 1'b0;

    unique case (phase_r)
      PH_TYPE: begin
        res0.kind       = KIND_TYPE;
        res0.field_byte = b;
        push_n          = 2'd1;
        fbc_nxt         = '0;
        links_rem_nxt   = '0;
        items_rem_nxt   = '0;
        cur_link_nxt    = '0;
        phase_nxt       = PH_NODE;
      end
      PH_NODE: begin
        res0.kind       = KIND_NODE_BYTE;
        res0.field_byte = b;
        push_n          = 2'd1;
        fbc_nxt         = fbc_inc;
        if (fbc_inc >= 8'(NODE_ID_BYTES)) begin
          fbc_nxt   = '0;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        res0.kind       = KIND_LINK_COUNT;
        res0.field_byte = b;
        push_n          = 2'd1;
        links_rem_nxt   = b;
        cur_link_nxt    = '0;
        fbc_nxt         = '0;
        if (b == 8'd0) begin
          complete = 1'b1;
        end else begin
          phase_nxt = PH_LID;
        end
      end
      PH_LID: begin
        res0.kind       = KIND_LINK_BYTE;
        res0.link_index = cur_link_r;
        res0.field_byte = b;
        push_n          = 2'd1;
        fbc_nxt         = fbc_inc;
        if (fbc_inc >= 8'(LINK_ID_BYTES)) begin
          fbc_nxt   = '0;
          phase_nxt = PH_ICNT;
        end
      end
      PH_ICNT: begin
        res0.kind       = KIND_ITEM_COUNT;
        res0.link_index = cur_link_r;
        res0.field_byte = b;
        push_n          = 2'd1;
        items_rem_nxt   = b;
        fbc_nxt         = '0;
        if (b == 8'd0) begin
          // Empty link record: close it.
          links_rem_nxt = links_rem_r - 8'd1;
          cur_link_nxt  = cur_link_r + 8'd1;
          if (links_rem_nxt == 8'd0) begin
            complete = 1'b1;
          end else begin
            phase_nxt = PH_LID;
          end
        end else begin
          phase_nxt = PH_ITEM;
        end
      end
      PH_ITEM: begin
        if (fbc_r == 8'd0) begin
          held_id_nxt = b;
          fbc_nxt     = 8'd1;
        end else if (fbc_r == 8'd1) begin
          held_hi_nxt = b;
          fbc_nxt     = 8'd2;
        end else begin
          // Low value byte completes the item.
          res0.kind       = KIND_QOS_ITEM;
          res0.link_index = cur_link_r;
          res0.item_id    = held_id_r;
          res0.item_value = {held_hi_r, b};
          push_n          = 2'd1;
          fbc_nxt         = '0;
          items_rem_nxt   = items_rem_r - 8'd1;
          if (items_rem_nxt == 8'd0) begin
            links_rem_nxt = links_rem_r - 8'd1;
            cur_link_nxt  = cur_link_r + 8'd1;
            if (links_rem_nxt == 8'd0) begin
              complete = 1'b1;
            end else begin
              phase_nxt = PH_LID;
            end
          end
        end
      end
      PH_TRAIL: begin
        // Drop bytes after a complete report; flag at the end mark.
        if (eop) begin
          res0.kind       = KIND_ERROR;
          res0.link_index = cur_link_r;
          res0.error_code = ERR_TRAILING;
          res0.last       = 1'b1;
          push_n          = 2'd1;
          clear_state     = 1'b1;
        end
      end
      default: begin
        clear_state = 1'b1;
      end
    endcase

    if (phase_r != PH_TRAIL) begin
      if (complete) begin
        if (eop) begin
          res0.last   = 1'b1;
          clear_state = 1'b1;
        end else begin
          phase_nxt = PH_TRAIL;
        end
      end else if (eop) begin
        // Early end: append a truncation error after any field result.
        if (push_n == 2'd0) begin
          res0.kind       = KIND_ERROR;
          res0.link_index = cur_link_nxt;
          res0.error_code = ERR_TRUNCATED;
          res0.last       = 1'b1;
          push_n          = 2'd1;
        end else begin
          res1.kind       = KIND_ERROR;
          res1.link_index = cur_link_nxt;
          res1.error_code = ERR_TRUNCATED;
          res1.last       = 1'b1;
          push_n          = 2'd2;
        end
        clear_state = 1'b1;
      end
    end

    if (clear_state) begin
      phase_nxt     = PH_TYPE;
      fbc_nxt       = '0;
      links_rem_nxt = '0;
      items_rem_nxt = '0;
      cur_link_nxt  = '0;
      held_id_nxt   = '0;
      held_hi_nxt   = '0;
    end
  end

  assign cnt_nxt = cnt_r + OUT_CNT_W'(in_acc ? push_n : 2'd0) - OUT_CNT_W'(out_acc);

  // Parser state and queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      fbc_r       <= '0;
      links_rem_r <= '0;
      items_rem_r <= '0;
      cur_link_r  <= '0;
      held_id_r   <= '0;
      held_hi_r   <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        fbc_r       <= fbc_nxt;
        links_rem_r <= links_rem_nxt;
        items_rem_r <= items_rem_nxt;
        cur_link_r  <= cur_link_nxt;
        held_id_r   <= held_id_nxt;
        held_hi_r   <= held_hi_nxt;
        wr_ptr_r    <= wr_ptr_r + OUT_PTR_W'(push_n);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage: write up to two results per accepted byte.
  always_ff @(posedge clk) begin
    if (in_acc && (push_n != 2'd0)) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (in_acc && (push_n == 2'd2)) begin
      queue_r[wr_ptr_r + OUT_PTR_W'(1)] <= res1;
    end
  end

  // Queue never overfills.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  // Every end mark taken returns the parser to the type byte.
  a_eop_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.end_of_packet) |=> (phase_r == PH_TYPE))
    else $error("parser did not resync after end of packet");

  // An error beat always closes the packet.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == KIND_ERROR)) |-> out_data.last)
    else $error("error beat without last");

  // Item byte position stays within the three-byte item.
  a_item_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ITEM) |-> (fbc_r <= 8'd2))
    else $error("item byte position out of range");

endmodule
